### hdl/steq_pkg.sv
// steq_pkg: shared types, codes and time helpers for the sorted timer event queue
// used by steq_cell, sorted_timer_event_queue_unit and steq_checker
package steq_pkg;

  localparam int SLOT_W = 4;
  localparam int TIME_W = 32;
  localparam int REQ_W = 3;
  localparam int STAT_W = 3;

  // wraparound distance at or above this counts as past
  localparam logic [TIME_W-1:0] PAST_LIMIT = 32'h8000_0000;

  // request codes
  localparam logic [REQ_W-1:0] REQ_SCHEDULE  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CANCEL    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PROCESS   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TIME_NEXT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_QUERY     = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STATUS_SUCCESS       = 3'd0;
  localparam logic [STAT_W-1:0] STATUS_ALREADY       = 3'd1;
  localparam logic [STAT_W-1:0] STATUS_INVALID_ARGS  = 3'd2;
  localparam logic [STAT_W-1:0] STATUS_INVALID_STATE = 3'd3;
  localparam logic [STAT_W-1:0] STATUS_NOT_FOUND     = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] fire_time;
    logic [TIME_W-1:0] context_req;
  } steq_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] out_slot;
    logic [TIME_W-1:0] out_context;
    logic [TIME_W-1:0] time_value;
    logic              last;
  } steq_out_t;

  // one queue position as held by a cell
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] fire_time;
    logic [TIME_W-1:0] ctx;
  } cell_data_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_EVAL,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_POP
  } cell_op_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    cell_op_t          op;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] fire_time;
    logic [TIME_W-1:0] ctx;
  } cell_cmd_t;

  // per-cell slot lookup result
  typedef struct packed {
    logic              hit;
    logic [TIME_W-1:0] hit_time;
  } cell_stat_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_DECIDE,
    FSM_POP
  } fsm_t;

  // true when the wraparound distance from 'from' to 'to' is zero or past
  function automatic logic is_due(input logic [TIME_W-1:0] from,
                                  input logic [TIME_W-1:0] to);
    logic [TIME_W-1:0] d;
    d = to - from;
    return (d >= PAST_LIMIT) || (d == '0);
  endfunction

  // wraparound distance clamped at zero for the past
  function automatic logic [TIME_W-1:0] ahead(input logic [TIME_W-1:0] from,
                                              input logic [TIME_W-1:0] to);
    logic [TIME_W-1:0] d;
    d = to - from;
    return (d >= PAST_LIMIT) ? '0 : d;
  endfunction

endpackage

### hdl/steq_cell.sv
// steq_cell: one position of the ordered timer list, shifts left or right with neighbors
// depends on steq_pkg
module steq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  steq_pkg::cell_cmd_t cmd,
  input  steq_pkg::cell_data_t left_data,
  input  steq_pkg::cell_data_t right_data,
  input  logic                seen_in,
  output logic                seen_out,
  output steq_pkg::cell_data_t data_out,
  output steq_pkg::cell_stat_t stat_out
);

  logic                        valid_r, valid_nxt;
  logic [steq_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [steq_pkg::TIME_W-1:0] time_r, time_nxt;
  logic [steq_pkg::TIME_W-1:0] ctx_r, ctx_nxt;
  logic                        ins_hit_r, ins_hit_nxt;
  logic                        slot_hit_r, slot_hit_nxt;
  logic                        flag;

  // insert point uses the order flag, removal the slot match
  assign flag     = (cmd.op == steq_pkg::CELL_INSERT) ? ins_hit_r : slot_hit_r;
  assign seen_out = seen_in | flag;

  assign data_out = '{valid: valid_r, slot: slot_r, fire_time: time_r, ctx: ctx_r};
  assign stat_out = '{hit: slot_hit_r, hit_time: slot_hit_r ? time_r : '0};

  always_comb begin
    valid_nxt    = valid_r;
    slot_nxt     = slot_r;
    time_nxt     = time_r;
    ctx_nxt      = ctx_r;
    ins_hit_nxt  = ins_hit_r;
    slot_hit_nxt = slot_hit_r;
    unique case (cmd.op)
      steq_pkg::CELL_EVAL: begin
        // empty cells sit behind all full ones, so they always qualify
        ins_hit_nxt  = !valid_r || steq_pkg::is_due(time_r, cmd.fire_time);
        slot_hit_nxt = valid_r && (slot_r == cmd.slot);
      end
      steq_pkg::CELL_INSERT: begin
        if (seen_in) begin
          valid_nxt = left_data.valid;
          slot_nxt  = left_data.slot;
          time_nxt  = left_data.fire_time;
          ctx_nxt   = left_data.ctx;
        end else if (flag) begin
          valid_nxt = 1'b1;
          slot_nxt  = cmd.slot;
          time_nxt  = cmd.fire_time;
          ctx_nxt   = cmd.ctx;
        end
      end
      steq_pkg::CELL_REMOVE: begin
        if (seen_out) begin
          valid_nxt = right_data.valid;
          slot_nxt  = right_data.slot;
          time_nxt  = right_data.fire_time;
          ctx_nxt   = right_data.ctx;
        end
      end
      steq_pkg::CELL_POP: begin
        valid_nxt = right_data.valid;
        slot_nxt  = right_data.slot;
        time_nxt  = right_data.fire_time;
        ctx_nxt   = right_data.ctx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      ins_hit_r  <= 1'b0;
      slot_hit_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      ins_hit_r  <= ins_hit_nxt;
      slot_hit_r <= slot_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    time_r <= time_nxt;
    ctx_r  <= ctx_nxt;
  end

endmodule

### hdl/sorted_timer_event_queue_unit.sv
// sorted_timer_event_queue_unit: timer events kept in time order in a row of steq_cell
// a request is taken when start is high and busy low; busy then stays high in the decide
// state, so no new request is taken before the last one's result is registered; process
// stays busy in the pop state while events are due and emits one event per cycle, the last
// one flagged; results cannot be stalled; synchronous active-low reset empties the queue
module sorted_timer_event_queue_unit #(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  steq_pkg::steq_in_t in_req,
  output logic               out_valid,
  output steq_pkg::steq_out_t out_res
);

  // sequencer state
  steq_pkg::fsm_t      state_r, state_nxt;
  steq_pkg::steq_in_t  req_r, req_nxt;
  logic                out_valid_r, out_valid_nxt;
  steq_pkg::steq_out_t out_res_r, out_res_nxt;

  // cell row
  steq_pkg::cell_cmd_t  cmd;
  steq_pkg::cell_data_t cdata [SLOTS];
  steq_pkg::cell_stat_t cstat [SLOTS];
  logic [SLOTS:0]       seen;

  logic                        any_hit;
  logic [steq_pkg::TIME_W-1:0] hit_time;
  logic                        slot_ok;
  logic                        head_due;
  logic                        next_due;

  assign seen[0] = 1'b0;

  // position 0 is the list head; data moves right on insert, left on removal
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    steq_pkg::cell_data_t lft, rgt;
    if (g == 0) begin : g_first
      assign lft = '0;
    end else begin : g_inner_l
      assign lft = cdata[g-1];
    end
    if (g == SLOTS - 1) begin : g_final
      assign rgt = '0;
    end else begin : g_inner_r
      assign rgt = cdata[g+1];
    end
    steq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_data  (lft),
      .right_data (rgt),
      .seen_in    (seen[g]),
      .seen_out   (seen[g+1]),
      .data_out   (cdata[g]),
      .stat_out   (cstat[g])
    );
  end

  // slot lookup: at most one cell matches, so an or-merge picks its time
  always_comb begin
    any_hit  = 1'b0;
    hit_time = '0;
    for (int i = 0; i < SLOTS; i++) begin
      any_hit  = any_hit | cstat[i].hit;
      hit_time = hit_time | cstat[i].hit_time;
    end
  end

  assign slot_ok  = (32'(req_r.slot) < 32'(SLOTS));
  assign head_due = cdata[0].valid && steq_pkg::is_due(req_r.now, cdata[0].fire_time);
  assign next_due = cdata[1].valid && steq_pkg::is_due(req_r.now, cdata[1].fire_time);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = '{status: steq_pkg::STATUS_SUCCESS, out_slot: '0, out_context: '0,
                      time_value: '0, last: 1'b1};
    cmd           = '{op: steq_pkg::CELL_HOLD, slot: req_r.slot,
                      fire_time: req_r.fire_time, ctx: req_r.context_req};
    unique case (state_r)
      steq_pkg::FSM_IDLE: begin
        // every cell compares against the incoming beat right away
        cmd = '{op: steq_pkg::CELL_HOLD, slot: in_req.slot,
                fire_time: in_req.fire_time, ctx: in_req.context_req};
        if (start) begin
          cmd.op    = steq_pkg::CELL_EVAL;
          req_nxt   = in_req;
          state_nxt = steq_pkg::FSM_DECIDE;
        end
      end
      steq_pkg::FSM_DECIDE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = steq_pkg::FSM_IDLE;
        unique case (req_r.req_type)
          steq_pkg::REQ_SCHEDULE: begin
            if (!slot_ok) begin
              out_res_nxt.status = steq_pkg::STATUS_INVALID_ARGS;
            end else if (any_hit) begin
              out_res_nxt.status = steq_pkg::STATUS_ALREADY;
            end else if ((req_r.fire_time - req_r.now) >= steq_pkg::PAST_LIMIT) begin
              // fire time behind now
              out_res_nxt.status = steq_pkg::STATUS_INVALID_ARGS;
            end else begin
              cmd.op = steq_pkg::CELL_INSERT;
            end
          end
          steq_pkg::REQ_CANCEL: begin
            if (!slot_ok) begin
              out_res_nxt.status = steq_pkg::STATUS_INVALID_ARGS;
            end else if (!any_hit) begin
              out_res_nxt.status = steq_pkg::STATUS_ALREADY;
            end else begin
              cmd.op = steq_pkg::CELL_REMOVE;
            end
          end
          steq_pkg::REQ_PROCESS: begin
            if (head_due) begin
              out_valid_nxt = 1'b0;
              state_nxt     = steq_pkg::FSM_POP;
            end else begin
              out_res_nxt.status = steq_pkg::STATUS_NOT_FOUND;
            end
          end
          steq_pkg::REQ_TIME_NEXT: begin
            if (cdata[0].valid) begin
              out_res_nxt.time_value = steq_pkg::ahead(req_r.now, cdata[0].fire_time);
            end else begin
              out_res_nxt.status = steq_pkg::STATUS_NOT_FOUND;
            end
          end
          steq_pkg::REQ_QUERY: begin
            if (!slot_ok) begin
              out_res_nxt.status = steq_pkg::STATUS_INVALID_ARGS;
            end else if (!any_hit) begin
              out_res_nxt.status = steq_pkg::STATUS_INVALID_STATE;
            end else begin
              out_res_nxt.time_value = hit_time;
            end
          end
          default: begin
            out_res_nxt.status = steq_pkg::STATUS_INVALID_ARGS;
          end
        endcase
      end
      steq_pkg::FSM_POP: begin
        // head is known due here; look one cell ahead to flag the last beat
        cmd.op                  = steq_pkg::CELL_POP;
        out_valid_nxt           = 1'b1;
        out_res_nxt.out_slot    = cdata[0].slot;
        out_res_nxt.out_context = cdata[0].ctx;
        out_res_nxt.last        = !next_due;
        state_nxt               = next_due ? steq_pkg::FSM_POP : steq_pkg::FSM_IDLE;
      end
      default: begin
        state_nxt = steq_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= steq_pkg::FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy      = (state_r != steq_pkg::FSM_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

### hdl/steq_checker.sv
// steq_checker: port-level checks on the timer queue's result stream
// depends on steq_pkg; bound to sorted_timer_event_queue_unit
module steq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input steq_pkg::steq_out_t out_res
);

  // an accepted beat keeps the unit busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // popped events follow one per cycle until the last one
  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.last) |=> out_valid)
    else $error("result burst broke before last beat");

  // a non-final beat only while the request is still in progress
  a_burst_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.last) |-> busy)
    else $error("non-final beat while idle");

  // any failing status ends the request
  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status != steq_pkg::STATUS_SUCCESS) |-> out_res.last)
    else $error("error status on a non-final beat");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.status <= steq_pkg::STATUS_NOT_FOUND))
    else $error("undefined status code");

endmodule

bind sorted_timer_event_queue_unit steq_checker u_steq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);

### tb/sv/sorted_timer_event_queue_unit_tb.sv
// sorted_timer_event_queue_unit_tb: self-checking bench for the sorted timer event queue,
// with a request driver, a result monitor and an in-bench model of the time-ordered queue
// depends on steq_pkg and sorted_timer_event_queue_unit
module sorted_timer_event_queue_unit_tb;
  import steq_pkg::*;

  localparam int SLOT_COUNT = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [TIME_W-1:0] HALF_RANGE = 32'h8000_0000;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  steq_in_t  in_req = '0;
  logic      out_valid;
  steq_out_t out_res;

  sorted_timer_event_queue_unit #(
    .SLOTS(SLOT_COUNT)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_res(out_res)
  );

  // request beats waiting to be driven, results predicted but not yet seen
  steq_in_t  req_backlog[$];
  steq_out_t predicted_results[$];

  // mirror of the queue contents: per-slot time, context, armed flag, firing order
  logic [TIME_W-1:0] slot_fire_time[SLOT_COUNT];
  logic [TIME_W-1:0] slot_context[SLOT_COUNT];
  bit                slot_armed[SLOT_COUNT];
  logic [SLOT_W-1:0] fire_order[$];

  int unsigned       sender_idle_pct = 0;
  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;
  logic [TIME_W-1:0] gen_now;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // distance from one time to another, anything half a wrap or more away is past
  function automatic logic [TIME_W-1:0] time_ahead(input logic [TIME_W-1:0] from,
                                                   input logic [TIME_W-1:0] to);
    logic [TIME_W-1:0] d;
    d = to - from;
    return (d >= HALF_RANGE) ? '0 : d;
  endfunction

  // apply one accepted request to the mirror and queue the results it should give
  task automatic apply_timer_request(input steq_in_t rq);
    steq_out_t         r;
    logic [SLOT_W-1:0] s;
    logic [SLOT_W-1:0] h;
    int                pos;
    int                n;
    r = '0;
    r.last = 1'b1;
    s = rq.slot;
    case (rq.req_type)
      REQ_SCHEDULE: begin
        if (!slot_armed[s] && time_ahead(rq.now, rq.fire_time) == '0 &&
            rq.now != rq.fire_time) begin
          r.status = STATUS_INVALID_ARGS;
        end else if (slot_armed[s]) begin
          r.status = STATUS_ALREADY;
        end else begin
          slot_fire_time[s] = rq.fire_time;
          slot_context[s] = rq.context_req;
          // newest goes ahead of every entry due at or after its time
          pos = 0;
          while (pos < fire_order.size() &&
                 time_ahead(slot_fire_time[fire_order[pos]], rq.fire_time) != '0)
            pos++;
          fire_order.insert(pos, s);
          slot_armed[s] = 1'b1;
          r.status = STATUS_SUCCESS;
        end
      end
      REQ_CANCEL: begin
        if (!slot_armed[s]) begin
          r.status = STATUS_ALREADY;
        end else begin
          for (pos = 0; pos < fire_order.size(); pos++) begin
            if (fire_order[pos] == s) begin
              fire_order.delete(pos);
              break;
            end
          end
          slot_armed[s] = 1'b0;
          r.status = STATUS_SUCCESS;
        end
      end
      REQ_PROCESS: begin
        n = 0;
        while (fire_order.size() > 0 && n < SLOT_COUNT &&
               time_ahead(rq.now, slot_fire_time[fire_order[0]]) == '0) begin
          h = fire_order.pop_front();
          slot_armed[h] = 1'b0;
          n++;
          r.status = STATUS_SUCCESS;
          r.out_slot = h;
          r.out_context = slot_context[h];
          r.last = (fire_order.size() == 0 || n == SLOT_COUNT ||
                    time_ahead(rq.now, slot_fire_time[fire_order[0]]) != '0);
          predicted_results.push_back(r);
        end
        if (n == 0) begin
          r.status = STATUS_NOT_FOUND;
          predicted_results.push_back(r);
        end
      end
      REQ_TIME_NEXT: begin
        if (fire_order.size() == 0) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          r.status = STATUS_SUCCESS;
          r.time_value = time_ahead(rq.now, slot_fire_time[fire_order[0]]);
        end
      end
      REQ_QUERY: begin
        if (!slot_armed[s]) begin
          r.status = STATUS_INVALID_STATE;
        end else begin
          r.status = STATUS_SUCCESS;
          r.time_value = slot_fire_time[s];
        end
      end
      default: begin
        r.status = STATUS_INVALID_ARGS;
      end
    endcase
    if (rq.req_type != REQ_PROCESS)
      predicted_results.push_back(r);
  endtask

  // driver: a beat goes in when start is high and busy is low at the edge,
  // then the next beat is offered unless the sender idles this cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start)
        apply_timer_request(in_req);
      if (req_backlog.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        start <= 1'b1;
        in_req <= req_backlog.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic void check_field(input string name, input logic [TIME_W-1:0] want,
                                      input logic [TIME_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // monitor: every strobed result beat is matched against the oldest prediction
  always @(posedge clk) begin
    steq_out_t want;
    if (rst_n && out_valid) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %h", $time, out_res);
        mismatches++;
      end else begin
        want = predicted_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_res.status));
        check_field("out_slot", 32'(want.out_slot), 32'(out_res.out_slot));
        check_field("out_context", want.out_context, out_res.out_context);
        check_field("time_value", want.time_value, out_res.time_value);
        check_field("last", 32'(want.last), 32'(out_res.last));
      end
    end
  end

  task automatic push_req(input logic [REQ_W-1:0] kind, input logic [SLOT_W-1:0] s,
                          input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] ft,
                          input logic [TIME_W-1:0] ctx);
    steq_in_t rq;
    rq.req_type = kind;
    rq.slot = s;
    rq.now = now;
    rq.fire_time = ft;
    rq.context_req = ctx;
    req_backlog.push_back(rq);
  endtask

  // random request around a drifting notion of the current time, so that
  // schedules mostly land just ahead and processing keeps finding due events
  task automatic push_random_req();
    int unsigned       pick;
    int unsigned       shape;
    logic [TIME_W-1:0] ft;
    logic [TIME_W-1:0] now;
    pick = $urandom_range(0, 99);
    shape = $urandom_range(0, 99);
    now = gen_now;
    ft = $urandom;
    if (pick < 40) begin
      if (shape < 70) ft = gen_now + $urandom_range(0, 64);
      else if (shape < 80) ft = gen_now - $urandom_range(1, 32'h7FFF_FFFF);
      else if (shape < 90) ft = gen_now;
      else if (shape < 95) ft = gen_now + $urandom_range(32'h7FFF_FF00, 32'h7FFF_FFFF);
      push_req(REQ_SCHEDULE, 4'($urandom_range(0, 15)), now, ft, $urandom);
    end else if (pick < 60) begin
      gen_now = gen_now + $urandom_range(0, 48);
      now = (shape < 10) ? $urandom : gen_now;
      push_req(REQ_PROCESS, 4'($urandom_range(0, 15)), now, ft, $urandom);
    end else if (pick < 70) begin
      push_req(REQ_CANCEL, 4'($urandom_range(0, 15)), now, ft, $urandom);
    end else if (pick < 80) begin
      push_req(REQ_TIME_NEXT, 4'($urandom_range(0, 15)), now, ft, $urandom);
    end else if (pick < 92) begin
      push_req(REQ_QUERY, 4'($urandom_range(0, 15)), now, ft, $urandom);
    end else begin
      // unknown request codes
      push_req(3'($urandom_range(5, 7)), 4'($urandom_range(0, 15)), $urandom, ft,
               $urandom);
    end
  endtask

  // try to arm every slot close together, then pop all due events in one process beat
  task automatic push_full_burst();
    for (int s = 0; s < SLOT_COUNT; s++)
      push_req(REQ_SCHEDULE, 4'(s), gen_now, gen_now + $urandom_range(1, 40), $urandom);
    gen_now = gen_now + 64;
    push_req(REQ_PROCESS, 4'd0, gen_now, $urandom, $urandom);
  endtask

  task automatic wait_drained();
    while (req_backlog.size() != 0 || start || predicted_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    logic [TIME_W-1:0] t0;
    int unsigned       idle_phase[4];
    idle_phase = '{0, 84, 0, 14};
    t0 = 32'hFFFF_FF00;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty queue, rejects, tie order across the wrap
    push_req(REQ_TIME_NEXT, 4'd0, '1, '0, '0);
    push_req(REQ_PROCESS, 4'd15, t0, '1, '1);
    push_req(REQ_QUERY, 4'd3, t0, '0, '0);
    push_req(REQ_CANCEL, 4'd3, t0, '0, '0);
    push_req(REQ_SCHEDULE, 4'd0, t0, t0, '1);
    push_req(REQ_SCHEDULE, 4'd0, t0, t0 + 16, 32'd1);
    push_req(REQ_SCHEDULE, 4'd1, t0, t0 - 1, 32'd2);
    push_req(REQ_SCHEDULE, 4'd1, t0, t0 + HALF_RANGE, 32'd3);
    push_req(REQ_SCHEDULE, 4'd1, t0, t0 + 32'h7FFF_FFFF, '0);
    push_req(REQ_SCHEDULE, 4'd2, t0, t0 + 32'h200, $urandom);
    push_req(REQ_SCHEDULE, 4'd15, t0, t0 + 32'h200, $urandom);
    push_req(REQ_SCHEDULE, 4'd4, t0, t0 + 32'h100, 32'h5A5A_A5A5);
    push_req(REQ_QUERY, 4'd15, '1, '1, '1);
    push_req(REQ_TIME_NEXT, 4'd0, t0 + 8, '0, '0);
    push_req(REQ_TIME_NEXT, 4'd0, t0 - 4, '0, '0);
    push_req(3'd5, 4'd15, '1, '1, '1);
    push_req(3'd6, 4'd0, '0, '0, '0);
    push_req(3'd7, 4'd7, $urandom, $urandom, $urandom);
    push_req(REQ_CANCEL, 4'd4, t0, '0, '0);
    push_req(REQ_PROCESS, 4'd0, t0 + 32'h200, '0, '0);
    push_req(REQ_TIME_NEXT, 4'd0, t0 + 32'h200, '0, '0);
    push_req(REQ_PROCESS, 4'd0, t0 + 32'h300, '0, '0);
    push_req(REQ_PROCESS, 4'd0, t0 + 32'h7FFF_FFFF, '0, '0);
    push_req(REQ_TIME_NEXT, 4'd0, t0, '0, '0);

    // random phases, each with its own sender idling
    foreach (idle_phase[p]) begin
      wait_drained();
      repeat (4) @(negedge clk);
      sender_idle_pct = idle_phase[p];
      gen_now = $urandom;
      push_full_burst();
      for (int i = 0; i < 57; i++)
        push_random_req();
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (predicted_results.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, predicted_results.size());
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
